// ===== sv/stl_pkg.sv =====
// Package with shared constants and the character classification function for the parser.
package stl_pkg;

   localparam int unsigned ValueWidth = 64;
   localparam int unsigned BaseWidth = 6;
   localparam int unsigned CharWidth = 8;
   localparam int unsigned OffsetWidth = 12;
   localparam int unsigned DefaultMaxLen = 4096;

   // Digit code returned for characters that are not digits in any base.
   localparam logic [BaseWidth-1:0] NoDigit = 6'd36;
   localparam logic [BaseWidth-1:0] MaxBase = 6'd36;

   localparam logic [CharWidth-1:0] ChZero = 8'h30;
   localparam logic [CharWidth-1:0] ChPlus = 8'h2B;
   localparam logic [CharWidth-1:0] ChMinus = 8'h2D;
   localparam logic [CharWidth-1:0] ChLowerX = 8'h78;
   localparam logic [CharWidth-1:0] ChUpperX = 8'h58;
   localparam logic [CharWidth-1:0] ChSpace = 8'h20;
   localparam logic [CharWidth-1:0] ChTab = 8'h09;
   localparam logic [CharWidth-1:0] ChCr = 8'h0D;

   localparam logic [ValueWidth-1:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [ValueWidth-1:0] NegLimit = 64'h8000_0000_0000_0000;

   // Maps 0-9, A-Z and a-z to 0..35; everything else maps to NoDigit.
   function automatic logic [BaseWidth-1:0] digit_value(input logic [CharWidth-1:0] c);
      logic [BaseWidth-1:0] d;
      d = NoDigit;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = BaseWidth'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         d = BaseWidth'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = BaseWidth'(c - 8'h57);
      end
      return d;
   endfunction

endpackage

// ===== sv/string_to_long_parser_top.sv =====
// Streaming string-to-long parser: one character per transaction, one result per string.
// A character is registered on entry, processed from the input register, and its result
// transaction (if any) is registered in the result register that drives the rsp channel.
// Throughput: one character per cycle while the result slot is free or draining, limited by
// the single 64x6 multiply-add and limit compare that fold a digit into the running magnitude.
// Reset (synchronous, active high) clears the pipeline valids, the radix register and the
// parse state, leaving the parser waiting for a start character.
module string_to_long_parser_top
   import stl_pkg::*;
#(
   parameter int unsigned MAX_LEN = DefaultMaxLen,
   localparam int unsigned PosWidth = $clog2(MAX_LEN),
   localparam int unsigned RspWidth = ((ValueWidth + OffsetWidth + 2 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,

   // Configuration write channel: radix setting.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BaseWidth-1:0]  csr_data,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CharWidth-1:0]  req_tdata,   // [7:0] ch
   input  logic                  req_tuser,   // [0] start_req

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // From bit 0 up: value (64), end_offset (12), found (1), overflow (1), zero fill.
   output logic [RspWidth-1:0]   rsp_tdata
);

   // Parser phases.
   localparam logic [2:0] PhDone   = 3'd0;
   localparam logic [2:0] PhLead   = 3'd1;
   localparam logic [2:0] PhSigned = 3'd2;
   localparam logic [2:0] PhZero   = 3'd3;
   localparam logic [2:0] PhHexPfx = 3'd4;
   localparam logic [2:0] PhDigits = 3'd5;

   localparam logic [PosWidth-1:0] PosTop = PosWidth'(MAX_LEN - 1);
   localparam int unsigned ProdWidth = ValueWidth + BaseWidth + 1;

   // Configuration register.
   logic [BaseWidth-1:0]  radix_ff;

   // Input register stage.
   logic                  in_valid_ff;
   logic                  in_start_ff;
   logic [CharWidth-1:0]  in_ch_ff;

   // Parse state.
   logic [2:0]            phase_ff, phase_in;
   logic                  negative_ff, negative_in;
   logic [BaseWidth-1:0]  base_ff, base_in;
   logic [ValueWidth-1:0] magnitude_ff, magnitude_in;
   logic                  clamped_ff, clamped_in;
   logic                  seen_ff, seen_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;

   // Result register.
   logic                   rsp_valid_ff;
   logic [ValueWidth-1:0]  rsp_value_ff, rsp_value_in;
   logic [OffsetWidth-1:0] rsp_end_ff, rsp_end_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                  emit;
   logic                  fire;

   // The processing stage advances when the result slot is free or being drained.
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign csr_ready  = 1'b1;

   // One pass over the current character. A start character first reloads the state and
   // latches the radix; the phase logic below then works on that reloaded state.
   always_comb begin
      logic [BaseWidth-1:0]  dv;
      logic                  is_space;
      logic                  do_signed;
      logic                  do_digit;
      logic                  do_acc;
      logic [1:0]            adv;
      logic [ProdWidth-1:0]  prod;
      logic [ProdWidth-1:0]  limit;

      phase_in     = phase_ff;
      negative_in  = negative_ff;
      base_in      = base_ff;
      magnitude_in = magnitude_ff;
      clamped_in   = clamped_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;

      emit         = 1'b0;
      rsp_value_in = '0;
      rsp_end_in   = '0;
      rsp_found_in = 1'b0;
      rsp_ovf_in   = 1'b0;

      dv        = digit_value(in_ch_ff);
      is_space  = (in_ch_ff >= ChTab && in_ch_ff <= ChCr) || in_ch_ff == ChSpace;
      do_signed = 1'b0;
      do_digit  = 1'b0;
      do_acc    = 1'b0;
      adv       = 2'd0;

      if (in_start_ff) begin
         phase_in     = PhLead;
         negative_in  = 1'b0;
         base_in      = radix_ff;
         magnitude_in = '0;
         clamped_in   = 1'b0;
         seen_in      = 1'b0;
         pos_in       = '0;
      end

      if (in_start_ff && (radix_ff == 6'd1 || radix_ff > MaxBase)) begin
         // Invalid base: report nothing found right away.
         emit     = 1'b1;
         phase_in = PhDone;
      end else begin
         unique case (phase_in)
            PhLead: begin
               if (is_space) begin
                  adv = 2'd1;
               end else if (in_ch_ff == ChPlus || in_ch_ff == ChMinus) begin
                  negative_in = (in_ch_ff == ChMinus);
                  phase_in    = PhSigned;
                  adv         = 2'd1;
               end else begin
                  do_signed = 1'b1;
               end
            end
            PhSigned: begin
               do_signed = 1'b1;
            end
            PhZero: begin
               if (in_ch_ff == ChLowerX || in_ch_ff == ChUpperX) begin
                  // The position stays on the 'x' until the next character decides.
                  phase_in = PhHexPfx;
               end else begin
                  if (base_in == '0) begin
                     base_in = 6'd8;
                  end
                  // The leading zero counts as a digit; the magnitude is still zero.
                  seen_in  = 1'b1;
                  do_digit = 1'b1;
               end
            end
            PhHexPfx: begin
               if (dv < 6'd16) begin
                  base_in  = 6'd16;
                  do_acc   = 1'b1;
                  phase_in = PhDigits;
                  adv      = 2'd2;
               end else begin
                  // Bare prefix: the zero is the number and parsing ends on the 'x'.
                  emit         = 1'b1;
                  rsp_end_in   = OffsetWidth'(pos_in);
                  rsp_found_in = 1'b1;
                  phase_in     = PhDone;
               end
            end
            PhDigits: begin
               do_digit = 1'b1;
            end
            default: begin
               // Idle between strings: characters are dropped.
            end
         endcase

         if (do_signed) begin
            if ((base_in == '0 || base_in == 6'd16) && in_ch_ff == ChZero) begin
               phase_in = PhZero;
               adv      = 2'd1;
            end else begin
               if (base_in == '0) begin
                  base_in = 6'd10;
               end
               if (dv < base_in) begin
                  do_digit = 1'b1;
               end else begin
                  emit     = 1'b1;
                  phase_in = PhDone;
               end
            end
         end

         if (do_digit) begin
            if (dv < base_in) begin
               do_acc   = 1'b1;
               phase_in = PhDigits;
               adv      = 2'd1;
            end else begin
               emit         = 1'b1;
               phase_in     = PhDone;
               rsp_end_in   = OffsetWidth'(pos_in);
               rsp_found_in = 1'b1;
               rsp_ovf_in   = clamped_in;
               if (clamped_in) begin
                  rsp_value_in = negative_in ? NegLimit : PosLimit;
               end else begin
                  rsp_value_in = negative_in ? (ValueWidth'(0) - magnitude_in) : magnitude_in;
               end
            end
         end
      end

      // Single multiply-add; the product compared against the limit replaces a division.
      prod  = ProdWidth'(magnitude_in) * ProdWidth'(base_in) + ProdWidth'(dv);
      limit = ProdWidth'(negative_in ? NegLimit : PosLimit);
      if (do_acc) begin
         seen_in = 1'b1;
         if (!clamped_in && base_in >= 6'd2) begin
            if (prod > limit) begin
               clamped_in = 1'b1;
            end else begin
               magnitude_in = prod[ValueWidth-1:0];
            end
         end
      end

      // Position advance, saturating at the last index.
      if (adv != 2'd0) begin
         pos_in = (pos_in < PosTop) ? pos_in + 1'b1 : PosTop;
      end
      if (adv == 2'd2) begin
         pos_in = (pos_in < PosTop) ? pos_in + 1'b1 : PosTop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         radix_ff <= csr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_start_ff <= req_tuser;
         in_ch_ff    <= req_tdata;
      end
   end

   // Parse state updates once per processed character.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhDone;
         negative_ff  <= 1'b0;
         base_ff      <= '0;
         magnitude_ff <= '0;
         clamped_ff   <= 1'b0;
         seen_ff      <= 1'b0;
         pos_ff       <= '0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         base_ff      <= base_in;
         magnitude_ff <= magnitude_in;
         clamped_ff   <= clamped_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
      end
   end

   // Result register: holds a finished transaction until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_value_ff <= rsp_value_in;
         rsp_end_ff   <= rsp_end_in;
         rsp_found_ff <= rsp_found_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RspWidth'({rsp_ovf_ff, rsp_found_ff, rsp_end_ff, rsp_value_ff});

`ifndef SYNTHESIS
   // A result with nothing found carries a zero value and a zero offset.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_value_ff == '0 && rsp_end_ff == '0)
      else $error("not-found result carries nonzero value or offset");

   // An overflowed result is always a found number clamped to a 64-bit limit.
   a_overflow_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |->
         rsp_found_ff && (rsp_value_ff == PosLimit || rsp_value_ff == NegLimit))
      else $error("overflow result is not clamped to a limit");

   // Between strings a character without a start flag never produces a result.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      fire && !in_start_ff && phase_ff == PhDone |=> !$rose(rsp_valid_ff))
      else $error("result produced while no string was active");
`endif

endmodule

// ===== sim/tb_string_to_long_parser_top.sv =====
// Self-checking testbench for the streaming string-to-long parser.
module tb_string_to_long_parser_top
   import stl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MaxLen = 4096;
   localparam int unsigned OffsetLsb = ValueWidth;
   localparam int unsigned FoundBit = OffsetLsb + OffsetWidth;
   localparam int unsigned OverflowBit = FoundBit + 1;
   localparam int unsigned RspBits = 80;
   localparam int unsigned ClockPeriod = 10;
   // The block registers a character, works on it from its input register and registers
   // the result for the rsp channel, so this settle time covers anything in flight.
   localparam int unsigned SettleCycles = 6;

   typedef logic [CharWidth-1:0] char_queue_type [$];

   // Parse progress within one string; ScanIdle waits for the next start flag.
   typedef enum logic [2:0] {
      ScanIdle,
      ScanLead,
      ScanSigned,
      ScanZero,
      ScanHexPrefix,
      ScanDigits
   } scan_phase_type;

   typedef struct {
      logic [ValueWidth-1:0]  value;
      logic [OffsetWidth-1:0] end_off;
      bit                     found;
      bit                     ovf;
   } parse_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [BaseWidth-1:0] csr_data;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [CharWidth-1:0] req_tdata;   // [7:0] ch
   logic                 req_tuser;   // [0] start_req
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   // From bit 0 up: value (64), end_offset (12), found (1), overflow (1), zero fill.
   logic [RspBits-1:0]   rsp_tdata;

   string_to_long_parser_top #(
      .MAX_LEN(MaxLen)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // Results predicted for accepted characters, oldest first.
   parse_result_type parse_results_due [$];
   int unsigned      mismatch_count;
   // Random idle bursts on both channels are enabled while this is set.
   bit               idle_on;
   // A nonzero value asks the result side to hold off for that many cycles.
   int unsigned      rsp_hold_cycles;

   // Predictor copy of the radix register and of the parse state.
   logic [BaseWidth-1:0]   radix_cfg;
   scan_phase_type         sc_phase;
   bit                     sc_neg;
   logic [BaseWidth-1:0]   sc_base;
   logic [ValueWidth-1:0]  sc_mag;
   bit                     sc_clamped;
   logic [OffsetWidth-1:0] sc_pos;

   always #(ClockPeriod / 2) clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // Digit weight of a character in bases up to 36, or NoDigit for anything else.
   function automatic logic [BaseWidth-1:0] char_digit(input logic [CharWidth-1:0] c);
      if (c >= "0" && c <= "9") return BaseWidth'(c - "0");
      if (c >= "A" && c <= "Z") return BaseWidth'(c - "A") + 6'd10;
      if (c >= "a" && c <= "z") return BaseWidth'(c - "a") + 6'd10;
      return NoDigit;
   endfunction

   // The offset stops at the top of its range instead of wrapping.
   function automatic void step_pos();
      if (sc_pos != {OffsetWidth{1'b1}}) sc_pos = sc_pos + 1'b1;
   endfunction

   // Folds one digit into the magnitude. Once the limit for the sign would be passed,
   // the magnitude freezes and later digits are only consumed.
   function automatic void fold_digit(input logic [BaseWidth-1:0] d);
      logic [ValueWidth-1:0] lim;
      lim = sc_neg ? NegLimit : PosLimit;
      if (sc_clamped || sc_base < 6'd2) return;
      if (sc_mag > (lim - ValueWidth'(d)) / ValueWidth'(sc_base)) begin
         sc_clamped = 1'b1;
      end else begin
         sc_mag = sc_mag * ValueWidth'(sc_base) + ValueWidth'(d);
      end
   endfunction

   function automatic bit close_string(output parse_result_type r,
                                       input logic [ValueWidth-1:0] v,
                                       input logic [OffsetWidth-1:0] off,
                                       input bit fnd, input bit ovf);
      r.value = v;
      r.end_off = off;
      r.found = fnd;
      r.ovf = ovf;
      sc_phase = ScanIdle;
      return 1'b1;
   endfunction

   // Inside the digit run: a digit of the base extends the number, anything else ends it.
   function automatic bit run_digit(input logic [CharWidth-1:0] c,
                                    output parse_result_type r);
      logic [BaseWidth-1:0]  d;
      logic [ValueWidth-1:0] v;
      d = char_digit(c);
      if (d < sc_base) begin
         fold_digit(d);
         sc_phase = ScanDigits;
         step_pos();
         return 1'b0;
      end
      if (sc_clamped) begin
         v = sc_neg ? NegLimit : PosLimit;
      end else begin
         v = sc_neg ? (64'd0 - sc_mag) : sc_mag;
      end
      return close_string(r, v, sc_pos, 1'b1, sc_clamped);
   endfunction

   // Advances the predicted parse by one accepted character; returns 1 with the
   // expected result when this character completes a string.
   function automatic bit parse_char(input bit first, input logic [CharWidth-1:0] c,
                                     output parse_result_type r);
      scan_phase_type       st;
      logic [BaseWidth-1:0] d;
      if (first) begin
         sc_neg = 1'b0;
         sc_mag = '0;
         sc_clamped = 1'b0;
         sc_pos = '0;
         sc_base = radix_cfg;
         sc_phase = ScanLead;
         // An unusable base answers on the start character itself.
         if (sc_base == 6'd1 || sc_base > MaxBase) return close_string(r, '0, '0, 1'b0, 1'b0);
      end
      st = sc_phase;
      if (st == ScanLead) begin
         if ((c >= ChTab && c <= ChCr) || c == ChSpace) begin
            step_pos();
            return 1'b0;
         end
         if (c == ChPlus || c == ChMinus) begin
            sc_neg = (c == ChMinus);
            sc_phase = ScanSigned;
            step_pos();
            return 1'b0;
         end
         // Neither blank nor sign: treat it as the first character after the sign.
         st = ScanSigned;
      end
      case (st)
         ScanSigned: begin
            if ((sc_base == 6'd0 || sc_base == 6'd16) && c == ChZero) begin
               sc_phase = ScanZero;
               step_pos();
               return 1'b0;
            end
            if (sc_base == 6'd0) sc_base = 6'd10;
            if (char_digit(c) < sc_base) return run_digit(c, r);
            return close_string(r, '0, '0, 1'b0, 1'b0);
         end
         ScanZero: begin
            // The offset stays on the x until the next character shows whether it
            // really opens a hex number.
            if (c == ChLowerX || c == ChUpperX) begin
               sc_phase = ScanHexPrefix;
               return 1'b0;
            end
            if (sc_base == 6'd0) sc_base = 6'd8;
            fold_digit('0);
            return run_digit(c, r);
         end
         ScanHexPrefix: begin
            d = char_digit(c);
            if (d < 6'd16) begin
               sc_base = 6'd16;
               fold_digit(d);
               sc_phase = ScanDigits;
               step_pos();
               step_pos();
               return 1'b0;
            end
            // A bare prefix: the zero alone was the number.
            return close_string(r, '0, sc_pos, 1'b1, 1'b0);
         end
         ScanDigits: return run_digit(c, r);
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch, %s", $time, what);
   endtask

   // Every result transaction is compared with the oldest prediction, field by field.
   always @(posedge clock) begin : rsp_check
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (parse_results_due.size() == 0) begin
            report_mismatch($sformatf("result transaction with none expected, tdata %h",
                                      rsp_tdata));
         end else begin
            want = parse_results_due.pop_front();
            if (rsp_tdata[ValueWidth-1:0] !== want.value)
               report_mismatch($sformatf("value %h, expected %h",
                                         rsp_tdata[ValueWidth-1:0], want.value));
            if (rsp_tdata[OffsetLsb +: OffsetWidth] !== want.end_off)
               report_mismatch($sformatf("end_offset %0d, expected %0d",
                                         rsp_tdata[OffsetLsb +: OffsetWidth], want.end_off));
            if (rsp_tdata[FoundBit] !== want.found)
               report_mismatch($sformatf("found %b, expected %b",
                                         rsp_tdata[FoundBit], want.found));
            if (rsp_tdata[OverflowBit] !== want.ovf)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_tdata[OverflowBit], want.ovf));
         end
      end
   end

   // The result side. It normally accepts at once, takes short random stalls while
   // idling is enabled, and holds off for a long counted stretch when asked to, so the
   // parser fills up and has to stall its input.
   initial begin : rsp_side
      int unsigned burst;
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 3);
            rsp_tready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   // Offers one character and returns at the edge where its transaction completes.
   // Valid is left high so the next character can follow without a gap.
   task automatic send_char(input bit first, input logic [CharWidth-1:0] c);
      parse_result_type r;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= first;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (parse_char(first, c, r)) parse_results_due.push_back(r);
   endtask

   // The start flag goes with the first character only.
   task automatic send_string(input char_queue_type s);
      foreach (s[i]) send_char(i == 0, s[i]);
   endtask

   // Text plus its terminating NUL.
   function automatic char_queue_type chars_of(input string t);
      char_queue_type q;
      foreach (t[i]) q.push_back(t[i]);
      q.push_back(8'h00);
      return q;
   endfunction

   // The sender pauses until every predicted result has arrived, then lets the block
   // settle, since a trailing character may still be in its pipeline.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (parse_results_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // The radix is only changed while the parser is idle.
   task automatic write_radix(input logic [BaseWidth-1:0] b);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      radix_cfg = b;
   endtask

   // One random string for the given radix setting. Most are well formed: optional
   // blanks, optional sign, a prefix where the base allows one, digits of the base and
   // a terminator. Some are plain noise over all byte values, and some are cut short so
   // that the next start abandons them.
   function automatic char_queue_type make_numeral(input logic [BaseWidth-1:0] radix);
      char_queue_type s;
      int unsigned    b;
      int unsigned    n;
      int unsigned    v;
      int unsigned    kind;
      string          lit;
      b = radix;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 6)) s.push_back(8'($urandom_range(0, 255)));
         s.push_back(8'h00);
         return s;
      end
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
         s.push_back(($urandom_range(0, 5) == 0) ? ChSpace : 8'($urandom_range(9, 13)));
      case ($urandom_range(0, 3))
         0: s.push_back(ChPlus);
         1: s.push_back(ChMinus);
         default: ;
      endcase
      if (b == 0) begin
         case ($urandom_range(0, 2))
            0: begin
               s.push_back(ChZero);
               s.push_back(($urandom_range(0, 1) == 1) ? ChLowerX : ChUpperX);
               b = 16;
            end
            1: begin
               s.push_back(ChZero);
               b = 8;
            end
            default: b = 10;
         endcase
      end else if (b == 16 && $urandom_range(0, 1) == 1) begin
         s.push_back(ChZero);
         s.push_back(($urandom_range(0, 1) == 1) ? ChLowerX : ChUpperX);
      end else if (b == 1 || b > 36) begin
         b = 10;
      end
      if (b == 10 && $urandom_range(0, 7) == 0) begin
         // Right at the limits of the signed range.
         lit = "922337203685477580";
         foreach (lit[i]) s.push_back(lit[i]);
         s.push_back(ChZero + 8'($urandom_range(7, 9)));
      end else begin
         if ($urandom_range(0, 7) == 0) begin
            n = (b < 8) ? $urandom_range(40, 70) : $urandom_range(18, 32);
         end else begin
            n = $urandom_range(1, 8);
         end
         repeat (n) begin
            v = $urandom_range(0, b - 1);
            if (v < 10) begin
               s.push_back(ChZero + 8'(v));
            end else begin
               s.push_back(8'(v - 10) + (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41));
            end
         end
      end
      if (kind == 1) begin
         while (s.size() > 1 && $urandom_range(0, 1) == 1) void'(s.pop_back());
         return s;
      end
      // An odd terminator or stray characters may come before the NUL.
      if ($urandom_range(0, 3) == 0) s.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) s.push_back(8'($urandom_range(0, 255)));
      s.push_back(8'h00);
      return s;
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Bases 1 and 63 answer on the start character; characters without a start after
   // that are strays and must produce nothing.
   task automatic test_invalid_radix();
      write_radix(6'd1);
      send_char(1'b1, "7");
      send_char(1'b0, "5");
      write_radix(6'd63);
      send_char(1'b1, 8'hFF);
      send_char(1'b0, 8'h00);
   endtask

   // Auto-detection: hex after a 0x prefix with blanks and a sign, a bare prefix,
   // octal after a leading zero, and a string with a sign but no digits.
   task automatic test_auto_radix();
      write_radix(6'd0);
      send_string(chars_of(" -0x1F"));
      send_string(chars_of("0xg"));
      send_string(chars_of("017"));
      send_string(chars_of("\t+"));
   endtask

   // Base 16 with an upper-case prefix, a start that abandons a string in progress, a
   // negative overflow in base 36 that clamps to the minimum, and a base 2 string with no valid digit.
   task automatic test_explicit_radix();
      write_radix(6'd16);
      send_string(chars_of("0XfF"));
      send_char(1'b1, "1");
      send_char(1'b0, "2");
      send_char(1'b1, "9");
      send_char(1'b0, 8'h00);
      write_radix(6'd36);
      send_string(chars_of("-zzzzzzzzzzzzz"));
      write_radix(6'd2);
      send_string(chars_of("2"));
   endtask

   // A long run of leading blanks before the digits moves the end offset far out.
   task automatic test_long_string();
      char_queue_type s;
      write_radix(6'd10);
      repeat (200) s.push_back(ChSpace);
      s.push_back("1");
      s.push_back("2");
      s.push_back(8'h00);
      send_string(s);
   endtask

   // The result side stalls for a long stretch while one-digit strings keep coming,
   // so the parser must stall its input; then the sender waits for everything.
   task automatic test_backpressure();
      char_queue_type s;
      write_radix(6'd10);
      rsp_hold_cycles = 150;
      repeat (60) begin
         s.delete();
         s.push_back(ChZero + 8'($urandom_range(0, 9)));
         s.push_back(8'h00);
         send_string(s);
      end
      drain_results();
   endtask

   task automatic test_random_strings(input logic [BaseWidth-1:0] radix,
                                      input int unsigned budget);
      char_queue_type s;
      int unsigned    sent;
      write_radix(radix);
      sent = 0;
      while (sent < budget) begin
         s = make_numeral(radix);
         send_string(s);
         sent += s.size();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      mismatch_count = 0;
      idle_on = 1'b1;
      rsp_hold_cycles = 0;
      radix_cfg = '0;
      sc_phase = ScanIdle;
      sc_neg = 1'b0;
      sc_base = '0;
      sc_mag = '0;
      sc_clamped = 1'b0;
      sc_pos = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_invalid_radix();
      test_auto_radix();
      test_explicit_radix();
      test_long_string();
      test_backpressure();

      test_random_strings(6'd10, 100);
      test_random_strings(6'd16, 100);
      test_random_strings(6'd0, 120);
      test_random_strings(6'd2, 90);
      test_random_strings(6'd8, 80);
      test_random_strings(6'd36, 80);
      test_random_strings(6'd37, 30);
      test_random_strings(6'($urandom_range(0, 63)), 80);
      test_random_strings(6'd0, 120);
      // The closing stretch runs at full rate on both channels.
      idle_on = 1'b0;
      test_random_strings(6'd10, 110);
      test_random_strings(6'd0, 120);

      drain_results();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== string_to_long_parser_top.f =====
sv/stl_pkg.sv
sv/string_to_long_parser_top.sv
sim/tb_string_to_long_parser_top.sv
